>>> rtl/core/random_pick_pool_defines.svh
// Assertion macros used by the random pick pool datapath.
`ifndef RANDOM_PICK_POOL_DEFINES_SVH
`define RANDOM_PICK_POOL_DEFINES_SVH

// Check that a condition implies a property in the same cycle.
`define RPP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("random_pick_pool: same-cycle check failed");

// Check that a condition implies a property in the following cycle.
`define RPP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("random_pick_pool: next-cycle check failed");

`endif

>>> rtl/core/rpp_pkg.sv
// Shared constants, codes and control types of the random pick pool.
package rpp_pkg;

  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 8;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int RND_W     = 32;
  localparam int DIV_CNT_W = $clog2(RND_W);

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_div;
    logic go_scan;
    logic div_last;
    logic hit;
  } dp_stat_t;

endpackage

>>> rtl/core/rpp_ram.sv
// Generic single-port-write, registered-read RAM.
module rpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rpp_ctrl.sv
// Sequencing state machine of the random pick pool.
module rpp_ctrl import rpp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t ctl,
  input  dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl.load      = (state == S_IDLE) && in_valid;
    ctl.div_step  = (state == S_DIV);
    ctl.scan_step = (state == S_SCAN);
    ctl.out_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stat.go_div) begin
            state <= S_DIV;
          end else if (stat.go_scan) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.hit) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rpp_dp.sv
// Datapath of the random pick pool: slot store, valid marks, divider, scanner.
`include "random_pick_pool_defines.svh"

module rpp_dp import rpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            ctl,
  output dp_stat_t             stat,
  input  logic [1:0]           cmd,
  input  logic [ITEM_BITS-1:0] data_in,
  input  logic [RND_W-1:0]     random_word,
  output logic [ITEM_BITS-1:0] data_out,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     occupancy
);

  logic [1:0]           cmd_q;
  logic [ITEM_BITS-1:0] din_q;
  logic [RND_W-1:0]     rnd_q;
  logic [1:0]           res_status;
  logic [CNT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [IDX_W-1:0]     pos;
  logic [CAPACITY-1:0]  slot_valid;
  logic [CNT_W-1:0]     item_count;

  logic                 is_enq;
  logic                 is_deq;
  logic                 is_pick;
  logic                 hit;
  logic [CNT_W:0]       shifted;
  logic [CNT_W-1:0]     rem_next;
  logic [1:0]           status_next;
  logic                 ram_we;
  logic                 ram_re;
  logic [ITEM_BITS-1:0] ram_rdata;

  assign is_enq  = (cmd_q == CMD_ENQ);
  assign is_deq  = (cmd_q == CMD_DEQ);
  assign is_pick = is_deq || (cmd_q == CMD_SAMPLE);
  assign hit     = is_enq ? !slot_valid[pos] : slot_valid[pos];

  // restoring division: one bit of the random word per cycle
  assign shifted  = {rem, rnd_q[RND_W-1]};
  assign rem_next = (shifted >= {1'b0, item_count})
                  ? CNT_W'(shifted - {1'b0, item_count})
                  : shifted[CNT_W-1:0];

  always_comb begin
    status_next = ST_OK;
    if (cmd == CMD_ENQ && item_count == CNT_W'(CAPACITY)) begin
      status_next = ST_FULL;
    end else if ((cmd == CMD_DEQ || cmd == CMD_SAMPLE) && item_count == '0) begin
      status_next = ST_EMPTY;
    end
  end

  always_comb begin
    stat.go_div   = is_pick && (res_status == ST_OK);
    stat.go_scan  = is_enq && (res_status == ST_OK);
    stat.div_last = (div_cnt == DIV_CNT_W'(RND_W - 1));
    stat.hit      = hit;
  end

  assign ram_we = ctl.scan_step && hit && is_enq;
  assign ram_re = ctl.scan_step && hit && is_pick;

  rpp_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (din_q),
    .re    (ram_re),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // transaction capture, divider and scan pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q      <= cmd;
      din_q      <= data_in;
      rnd_q      <= random_word;
      res_status <= status_next;
      rem        <= '0;
      div_cnt    <= '0;
      pos        <= '0;
    end
    if (ctl.div_step) begin
      rem     <= rem_next;
      rnd_q   <= {rnd_q[RND_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (stat.div_last) begin
        pos <= rem_next[IDX_W-1:0];
      end
    end
    if (ctl.scan_step && !hit) begin
      pos <= (pos == IDX_W'(CAPACITY - 1)) ? '0 : pos + IDX_W'(1);
    end
    if (ctl.out_load) begin
      data_out  <= (is_pick && res_status == ST_OK) ? ram_rdata : '0;
      status    <= res_status;
      occupancy <= item_count;
    end
  end

  // valid marks and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      item_count <= '0;
    end else if (ctl.scan_step && hit) begin
      if (is_enq) begin
        slot_valid[pos] <= 1'b1;
        item_count      <= item_count + CNT_W'(1);
      end else if (is_deq) begin
        slot_valid[pos] <= 1'b0;
        item_count      <= item_count - CNT_W'(1);
      end
    end
  end

  `RPP_ASSERT_NOW(a_count_matches_marks, 1'b1, $countones(slot_valid) == item_count)
  `RPP_ASSERT_NOW(a_enq_not_full, ram_we, item_count < CNT_W'(CAPACITY))
  `RPP_ASSERT_NEXT(a_start_below_count, ctl.div_step && stat.div_last, pos < item_count)
  `RPP_ASSERT_NEXT(a_deq_drops_one, ram_re && is_deq,
                   item_count == $past(item_count) - CNT_W'(1))

endmodule

>>> rtl/core/random_pick_pool.sv
// Random pick pool: 16 item slots with enqueue, random dequeue and random sample.
//
// Input channel: cmd, data_in and random_word travel with in_valid; a
// transaction is taken when in_valid is high and in_stall is low. Output
// channel: data_out, status and occupancy travel with out_valid, taken when
// out_valid is high and out_stall is low. Every command yields one result.
// One command is in work at a time; in_stall is high while it runs.
// Work done after acceptance, before the result can be loaded:
//   enqueue            slot scan from slot 0, taking the lowest free slot
//   dequeue / sample   modulo, then slot scan from the start slot
//   full, empty, code 3  no modulo and no scan
// The start slot is the bit-serial 32-bit modulo of the random word by the
// occupancy, one quotient bit per cycle.
// The result sits in an output register, so a new command is accepted while
// the receiver stalls; its result waits until that register is taken.
// Reset empties the pool (all slots free, occupancy zero) and drops any
// pending result.
module random_pick_pool import rpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [ITEM_BITS-1:0] data_in,
  input  logic [RND_W-1:0]     random_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ITEM_BITS-1:0] data_out,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     occupancy
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  rpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  rpp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .data_in     (data_in),
    .random_word (random_word),
    .data_out    (data_out),
    .status      (status),
    .occupancy   (occupancy)
  );

endmodule
